[src/mvsm_pkg.sv]
// Shared types, constants and tables for the multi-voice sample mixer.
package mvsm_pkg;

  localparam int VOICE_COUNT_DEF  = 4;
  localparam int SAMPLE_DEPTH_DEF = 16384;

  localparam int LEN_REGS    = 4;
  localparam int LEN_W       = 15;
  localparam int PERIOD_W    = 17;
  localparam int SAMPLE_W    = 16;
  localparam int LEVEL_W     = 16;
  localparam int ACT_W       = 4;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 17;

  // Reciprocal multiply for the voice-count divide: q = (mag * R) >> RECIP_SHIFT.
  localparam int RECIP_W     = 23;
  localparam int RECIP_SHIFT = 22;

  localparam int MIX_MAX     = 32767;
  localparam int MIX_MIN     = -32768;
  localparam int MIX_OFFSET  = 32768;
  localparam int LEVEL_SHIFT = 16;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 17'd2834;

  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_TRIGGER = 2'd1;
  localparam logic [1:0] CMD_WRITE   = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_VOICE0_LENGTH = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_VOICE1_LENGTH = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_VOICE2_LENGTH = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_VOICE3_LENGTH = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_PWM_PERIOD    = 3'd4;

  typedef struct packed {
    logic [1:0]          command;
    logic [1:0]          voice;
    logic [13:0]         sample_address;
    logic signed [15:0]  sample_value;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] pwm_level;
    logic [ACT_W-1:0]   active_voices;
  } out_item_t;

  // ceil(2^22 / count); exact floor division for magnitudes up to 2^19
  function automatic logic [RECIP_W-1:0] recip(input logic [3:0] count);
    logic [RECIP_W-1:0] r;
    unique case (count)
      4'd2:    r = 23'd2097152;
      4'd3:    r = 23'd1398102;
      4'd4:    r = 23'd1048576;
      4'd5:    r = 23'd838861;
      4'd6:    r = 23'd699051;
      4'd7:    r = 23'd599187;
      4'd8:    r = 23'd524288;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[src/mvsm_sample_ram.sv]
// Single-port-write, single-port-read sample store with registered read data.
module mvsm_sample_ram #(
  parameter int  DEPTH = mvsm_pkg::VOICE_COUNT_DEF * mvsm_pkg::SAMPLE_DEPTH_DEF,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [AW-1:0]                       waddr,
  input  logic signed [mvsm_pkg::SAMPLE_W-1:0] wdata,
  input  logic                                re,
  input  logic [AW-1:0]                       raddr,
  output logic signed [mvsm_pkg::SAMPLE_W-1:0] rdata
);

  logic [mvsm_pkg::SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/mvsm_level_calc.sv]
// Pipelined average, clamp, offset and PWM scaling of one tick's voice sum.
module mvsm_level_calc #(
  parameter int SUM_W = 18,
  parameter int CNT_W = 3
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [SUM_W-1:0]            sum,
  input  logic [CNT_W-1:0]                   count,
  input  logic [mvsm_pkg::PERIOD_W-1:0]      period,
  output logic                               done,
  output logic [mvsm_pkg::LEVEL_W-1:0]       level
);

  localparam int PW       = SUM_W + mvsm_pkg::RECIP_W;
  localparam int MW       = SUM_W + 2;
  localparam int SCALED_W = mvsm_pkg::LEVEL_W + mvsm_pkg::PERIOD_W;

  localparam logic signed [MW-1:0] MIX_MAX_C    = MW'(mvsm_pkg::MIX_MAX);
  localparam logic signed [MW-1:0] MIX_MIN_C    = MW'(mvsm_pkg::MIX_MIN);
  localparam logic signed [MW-1:0] MIX_OFFSET_C = MW'(mvsm_pkg::MIX_OFFSET);
  localparam logic [mvsm_pkg::PERIOD_W-1:0] LEVEL_CAP = mvsm_pkg::PERIOD_W'(16'hFFFF);

  logic [4:0] vld_r;

  // stage 1
  logic                         neg1_r, div1_r;
  logic [SUM_W-1:0]             mag1_r;
  logic [mvsm_pkg::RECIP_W-1:0] recip1_r;
  // stage 2
  logic                         neg2_r, div2_r;
  logic [SUM_W-1:0]             mag2_r;
  logic [PW-1:0]                prod2_r;
  // stage 3
  logic [mvsm_pkg::LEVEL_W-1:0] u3_r;
  // stage 4
  logic [SCALED_W-1:0]          scaled4_r;
  // stage 5
  logic [mvsm_pkg::LEVEL_W-1:0] level5_r;

  logic [SUM_W-1:0]             sum_mag;
  logic [SUM_W-1:0]             quot;
  logic signed [MW-1:0]         mix_mag, mix, mix_clamped, mix_off;
  logic [mvsm_pkg::PERIOD_W-1:0] lvl_raw, lvl_cap;

  assign sum_mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  always_comb begin
    quot    = div2_r ? SUM_W'(prod2_r >> mvsm_pkg::RECIP_SHIFT) : mag2_r;
    mix_mag = signed'(MW'(quot));
    mix     = neg2_r ? -mix_mag : mix_mag;
    if (mix > MIX_MAX_C) begin
      mix_clamped = MIX_MAX_C;
    end else if (mix < MIX_MIN_C) begin
      mix_clamped = MIX_MIN_C;
    end else begin
      mix_clamped = mix;
    end
    mix_off = mix_clamped + MIX_OFFSET_C;
  end

  always_comb begin
    lvl_raw = scaled4_r[SCALED_W-1:mvsm_pkg::LEVEL_SHIFT];
    if (period == '0) begin
      lvl_cap = '0;
    end else if (lvl_raw >= period) begin
      lvl_cap = period - 1'b1;
    end else begin
      lvl_cap = lvl_raw;
    end
    if (lvl_cap > LEVEL_CAP) begin
      lvl_cap = LEVEL_CAP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], start};
    end
    neg1_r    <= sum[SUM_W-1];
    mag1_r    <= sum_mag;
    div1_r    <= (count > CNT_W'(1));
    recip1_r  <= mvsm_pkg::recip(4'(count));
    neg2_r    <= neg1_r;
    div2_r    <= div1_r;
    mag2_r    <= mag1_r;
    prod2_r   <= PW'(mag1_r) * PW'(recip1_r);
    u3_r      <= mvsm_pkg::LEVEL_W'(mix_off);
    scaled4_r <= SCALED_W'(u3_r) * SCALED_W'(period);
    level5_r  <= mvsm_pkg::LEVEL_W'(lvl_cap);
  end

  assign done  = vld_r[4];
  assign level = level5_r;

endmodule

[src/multi_voice_sample_mixer.sv]
// Top level of the multi-voice sample mixer: command handling, voice sequencer, result register.
//
// Usage: each input transaction on in_* carries one command. A write command
// stores a signed 16-bit sample word into the addressed voice's region of the
// sample store; a trigger command restarts a voice at frame 0 and marks it
// active; a tick command mixes all voices and yields one result transaction
// on out_* (pwm_level and the per-voice active flags after the tick).
// Writes and triggers produce no result. A tick walks the voices one at a
// time (store read, then accumulate, for each voice), then passes the sum
// through a five-stage average/clamp/scale pipeline, whose level is then
// registered as the result. The sequencer handles one tick at a time; in_ready
// is low while a tick is in flight, so the next tick is taken only after the
// last one's level is registered.
// The result sits in an output register. A new tick is accepted while it
// waits; its voice walk runs, and the launch into the pipeline holds until
// out_ready frees the slot.
// Reset clears voice positions and active flags, lengths to 0 and the PWM
// period to 2834. Sample store contents are undefined until written; no
// clearing pass runs. Configuration writes (cfg_we) take effect at once.
module multi_voice_sample_mixer #(
  parameter int VOICE_COUNT  = mvsm_pkg::VOICE_COUNT_DEF,
  parameter int SAMPLE_DEPTH = mvsm_pkg::SAMPLE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  mvsm_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output mvsm_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [mvsm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mvsm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int MEM_DEPTH = VOICE_COUNT * SAMPLE_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int VI_W      = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int SUM_W     = mvsm_pkg::SAMPLE_W + $clog2(VOICE_COUNT);
  localparam int CNT_W     = $clog2(VOICE_COUNT + 1);
  localparam int LEN_W     = mvsm_pkg::LEN_W;

  localparam logic [AW-1:0]   DEPTH_A    = AW'(SAMPLE_DEPTH);
  localparam logic [16:0]     DEPTH_17   = 17'(SAMPLE_DEPTH);
  localparam logic [3:0]      VCOUNT_4   = 4'(VOICE_COUNT);
  localparam logic [VI_W-1:0] LAST_VOICE = VI_W'(VOICE_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_ACC,
    S_LAUNCH,
    S_CALC
  } state_t;

  state_t                          state_r;
  logic [LEN_W-1:0]                len_r [mvsm_pkg::LEN_REGS];
  logic [mvsm_pkg::PERIOD_W-1:0]   period_r;
  logic [LEN_W-1:0]                pos_r [VOICE_COUNT];
  logic [VOICE_COUNT-1:0]          active_r;
  logic [VI_W-1:0]                 vidx_r;
  logic                            play_r;
  logic signed [SUM_W-1:0]         sum_r, sum_nxt;
  logic [CNT_W-1:0]                cnt_r, cnt_nxt;
  logic                            out_valid_r;
  mvsm_pkg::out_item_t             out_data_r;

  logic [LEN_W-1:0]                elen [VOICE_COUNT];
  logic [mvsm_pkg::ACT_W-1:0]      act_vec;
  logic                            in_accept;
  logic                            voice_ok, addr_ok;
  logic [VI_W-1:0]                 in_vidx;
  logic                            mem_we, mem_re;
  logic [AW-1:0]                   mem_waddr, mem_raddr;
  logic signed [mvsm_pkg::SAMPLE_W-1:0] mem_rdata;
  logic [LEN_W-1:0]                cur_pos, cur_len, pos_inc;
  logic                            play;
  logic                            calc_start, calc_done;
  logic [mvsm_pkg::LEVEL_W-1:0]    calc_level;

  // Effective length per voice: capped at the store depth; voices without a
  // length register play nothing.
  for (genvar g = 0; g < VOICE_COUNT; g++) begin : g_elen
    if (g < mvsm_pkg::LEN_REGS) begin : g_reg
      assign elen[g] = ({2'b00, len_r[g]} > DEPTH_17) ? LEN_W'(SAMPLE_DEPTH) : len_r[g];
    end else begin : g_none
      assign elen[g] = '0;
    end
  end

  for (genvar g = 0; g < mvsm_pkg::ACT_W; g++) begin : g_act
    if (g < VOICE_COUNT) begin : g_on
      assign act_vec[g] = active_r[g];
    end else begin : g_off
      assign act_vec[g] = 1'b0;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign voice_ok  = ({2'b00, in_data.voice} < VCOUNT_4);
  assign addr_ok   = ({3'b000, in_data.sample_address} < DEPTH_17);
  assign in_vidx   = VI_W'(in_data.voice);

  // Sample writes go straight to the store on acceptance; reads only happen
  // during a tick, so no same-entry overlap is possible.
  assign mem_we    = in_accept && (in_data.command == mvsm_pkg::CMD_WRITE) && voice_ok && addr_ok;
  assign mem_waddr = AW'(in_data.voice) * DEPTH_A + AW'(in_data.sample_address);

  assign cur_pos   = pos_r[vidx_r];
  assign cur_len   = elen[vidx_r];
  assign pos_inc   = cur_pos + 1'b1;
  assign play      = active_r[vidx_r] && (cur_pos < cur_len);
  assign mem_re    = (state_r == S_READ);
  assign mem_raddr = AW'(vidx_r) * DEPTH_A + AW'(cur_pos);

  // Accumulate the word fetched in the previous cycle.
  assign sum_nxt = play_r ? sum_r + SUM_W'(mem_rdata) : sum_r;
  assign cnt_nxt = play_r ? cnt_r + 1'b1 : cnt_r;

  // Launch only when the output slot is sure to be free when the level lands.
  assign calc_start = (state_r == S_LAUNCH) && (!out_valid_r || out_ready);

  mvsm_sample_ram #(
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_data.sample_value),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mvsm_level_calc #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_calc (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (calc_start),
    .sum    (sum_r),
    .count  (cnt_r),
    .period (period_r),
    .done   (calc_done),
    .level  (calc_level)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      period_r    <= mvsm_pkg::PERIOD_RESET;
      active_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < mvsm_pkg::LEN_REGS; i++) begin
        len_r[i] <= '0;
      end
      for (int i = 0; i < VOICE_COUNT; i++) begin
        pos_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          mvsm_pkg::CFG_VOICE0_LENGTH: len_r[0] <= cfg_wdata[LEN_W-1:0];
          mvsm_pkg::CFG_VOICE1_LENGTH: len_r[1] <= cfg_wdata[LEN_W-1:0];
          mvsm_pkg::CFG_VOICE2_LENGTH: len_r[2] <= cfg_wdata[LEN_W-1:0];
          mvsm_pkg::CFG_VOICE3_LENGTH: len_r[3] <= cfg_wdata[LEN_W-1:0];
          mvsm_pkg::CFG_PWM_PERIOD:    period_r <= cfg_wdata;
          default: ;
        endcase
      end

      // Drop the held result once the receiver takes it.
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            unique case (in_data.command)
              mvsm_pkg::CMD_TRIGGER: begin
                if (voice_ok) begin
                  pos_r[in_vidx]    <= '0;
                  active_r[in_vidx] <= 1'b1;
                end
              end
              mvsm_pkg::CMD_TICK: begin
                vidx_r  <= '0;
                sum_r   <= '0;
                cnt_r   <= '0;
                state_r <= S_READ;
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          // Fetch this voice's word, advance it, retire it at its length.
          play_r <= play;
          if (play) begin
            pos_r[vidx_r] <= pos_inc;
            if (pos_inc >= cur_len) begin
              active_r[vidx_r] <= 1'b0;
            end
          end
          state_r <= S_ACC;
        end
        S_ACC: begin
          sum_r <= sum_nxt;
          cnt_r <= cnt_nxt;
          if (vidx_r == LAST_VOICE) begin
            state_r <= S_LAUNCH;
          end else begin
            vidx_r  <= vidx_r + 1'b1;
            state_r <= S_READ;
          end
        end
        S_LAUNCH: begin
          if (calc_start) begin
            state_r <= S_CALC;
          end
        end
        S_CALC: begin
          if (calc_done) begin
            out_valid_r              <= 1'b1;
            out_data_r.pwm_level     <= calc_level;
            out_data_r.active_voices <= act_vec;
            state_r                  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[test/multi_voice_sample_mixer_tb.sv]
// Self-checking testbench for the multi-voice sample mixer: stimulus, predictor and result checks.
`timescale 1ns / 100ps

module multi_voice_sample_mixer_tb;

  localparam int VOICES = mvsm_pkg::VOICE_COUNT_DEF;
  localparam int DEPTH = mvsm_pkg::SAMPLE_DEPTH_DEF;
  localparam int LEN_W = mvsm_pkg::LEN_W;
  localparam int PERIOD_W = mvsm_pkg::PERIOD_W;
  localparam int SAMPLE_W = mvsm_pkg::SAMPLE_W;
  localparam int LEVEL_W = mvsm_pkg::LEVEL_W;
  localparam int ACT_W = mvsm_pkg::ACT_W;
  localparam int IDX_W = mvsm_pkg::CFG_INDEX_W;
  localparam int DATA_W = mvsm_pkg::CFG_DATA_W;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int NUM_PHASES = 8;
  localparam int PER_PHASE = 78;          // counted random items per phase

  // Command code the block must ignore; the package names only the live ones.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // Register indexes past the PWM period decode to nothing.
  localparam logic [IDX_W-1:0] CFG_UNMAPPED_LO = 3'd5;
  localparam logic [IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  mvsm_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mvsm_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_wdata = '0;

  multi_voice_sample_mixer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Mixer shadow: configuration, voice state and sample memory
  // ---------------------------------------------------------------------------
  logic [LEN_W-1:0] len_cfg [VOICES];
  logic [PERIOD_W-1:0] period_cfg;
  logic [LEN_W-1:0] play_pos [VOICES];
  bit playing [VOICES];
  logic signed [SAMPLE_W-1:0] pcm_mem [0:VOICES*DEPTH-1];

  // Stimulus bookkeeping: which store entries are written, and how far each
  // voice is written without a hole from frame 0. A voice is triggered only
  // when its playable length fits inside that prefix, so no tick ever reads
  // an entry that was never written.
  bit written_map [0:VOICES*DEPTH-1];
  int filled_to [VOICES];
  bit armed [VOICES];

  mvsm_pkg::in_item_t pending_cmds [$];
  mvsm_pkg::out_item_t pending_levels [$];

  bit in_xfer = 1'b0;
  bit out_xfer = 1'b0;
  int in_gap = 0;
  int out_stall = 0;
  int in_gap_max = 9;
  int out_stall_max = 9;

  int cycle_count = 0;
  int errors = 0;
  int ticks_done = 0;
  int writes_done = 0;
  int triggers_done = 0;
  int ignored_done = 0;
  int results_checked = 0;
  int reg_writes = 0;

  mvsm_pkg::out_item_t mix_res;
  mvsm_pkg::out_item_t mix_want;

  // Frames a voice can actually play: the store depth caps the length.
  function automatic int voice_span(logic [LEN_W-1:0] len);
    return (len > DEPTH) ? DEPTH : int'(len);
  endfunction

  // Apply one accepted command to the shadow; return 1 with the level on a tick.
  function automatic bit advance_mixer(input mvsm_pkg::in_item_t c,
                                       output mvsm_pkg::out_item_t res);
    int mix;
    int voices;
    int v;
    int span;
    longint lvl;
    logic [ACT_W-1:0] act;
    res = '0;
    case (c.command)
      mvsm_pkg::CMD_TRIGGER: begin
        play_pos[c.voice] = '0;
        playing[c.voice] = 1'b1;
        return 1'b0;
      end
      mvsm_pkg::CMD_WRITE: begin
        pcm_mem[int'(c.voice) * DEPTH + int'(c.sample_address)] = c.sample_value;
        return 1'b0;
      end
      mvsm_pkg::CMD_TICK: begin
        mix = 0;
        voices = 0;
        act = '0;
        for (v = 0; v < VOICES; v++) begin
          span = voice_span(len_cfg[v]);
          if (playing[v] && play_pos[v] < span) begin
            mix += pcm_mem[v * DEPTH + int'(play_pos[v])];
            voices++;
            play_pos[v] = play_pos[v] + 1'b1;
            // drop the voice once it runs off the end; a zero or stale length
            // keeps it flagged active without contributing
            if (play_pos[v] >= span) playing[v] = 1'b0;
          end
          act[v] = playing[v];
        end
        // SV integer divide truncates toward zero, as the mixer does
        if (voices > 1) mix = mix / voices;
        if (mix > mvsm_pkg::MIX_MAX) mix = mvsm_pkg::MIX_MAX;
        if (mix < mvsm_pkg::MIX_MIN) mix = mvsm_pkg::MIX_MIN;
        if (period_cfg == 0) begin
          lvl = 0;
        end else begin
          lvl = (longint'(mix + mvsm_pkg::MIX_OFFSET) * longint'(period_cfg))
                >>> mvsm_pkg::LEVEL_SHIFT;
          if (lvl >= period_cfg) lvl = period_cfg - 1;
          if (lvl > 65535) lvl = 65535;
        end
        res.pwm_level = lvl[LEVEL_W-1:0];
        res.active_voices = act;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Queue one command and track what it does to the written prefix.
  function automatic void queue_command(logic [1:0] cmd, int v, int addr, int val);
    mvsm_pkg::in_item_t c;
    c.command = cmd;
    c.voice = 2'(v);
    c.sample_address = 14'(addr);
    c.sample_value = 16'(val);
    pending_cmds.push_back(c);
    if (cmd == mvsm_pkg::CMD_WRITE) begin
      written_map[v * DEPTH + addr] = 1'b1;
      while (filled_to[v] < DEPTH && written_map[v * DEPTH + filled_to[v]])
        filled_to[v]++;
    end else if (cmd == mvsm_pkg::CMD_TRIGGER) begin
      armed[v] = 1'b1;
    end
  endfunction

  function automatic bit can_trigger(int v);
    return voice_span(len_cfg[v]) <= filled_to[v];
  endfunction

  // Mostly random words, with the two rails mixed in.
  function automatic int pick_sample();
    case ($urandom_range(0, 7))
      0: return mvsm_pkg::MIX_MAX;
      1: return mvsm_pkg::MIX_MIN;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // Short lengths keep voices finishing often; a triggered voice never gets
  // a length longer than its written prefix.
  function automatic logic [LEN_W-1:0] pick_length(int v);
    int len;
    len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
    if (armed[v] && voice_span(LEN_W'(len)) > filled_to[v]) len = filled_to[v];
    return LEN_W'(len);
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0d] mismatch: %s", cycle_count, msg);
  endtask

  // Write one register while the block is idle; mirror it in the shadow.
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx < mvsm_pkg::LEN_REGS) len_cfg[idx[1:0]] = data[LEN_W-1:0];
    else if (idx == mvsm_pkg::CFG_PWM_PERIOD) period_cfg = data;
    reg_writes++;
  endtask

  // Hold until every queued command is taken and every level has come back,
  // then let trailing writes and triggers retire.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_cmds.size() != 0 || in_valid || pending_levels.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present queued commands, idle a random number of cycles per item
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    in_xfer = rst_n && in_valid && in_ready;
    if (in_xfer) begin
      case (in_data.command)
        mvsm_pkg::CMD_TICK: ticks_done++;
        mvsm_pkg::CMD_TRIGGER: triggers_done++;
        mvsm_pkg::CMD_WRITE: writes_done++;
        default: ignored_done++;
      endcase
      if (advance_mixer(in_data, mix_res)) pending_levels.push_back(mix_res);
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_xfer) begin
      // hold valid and payload until the transaction is taken
    end else begin
      if (in_xfer) in_gap = $urandom_range(0, in_gap_max);
      if (in_gap > 0 || pending_cmds.size() == 0) begin
        if (in_gap > 0) in_gap--;
        in_valid <= 1'b0;
      end else begin
        in_data <= pending_cmds.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stall on results at random, compare each against the oldest level
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_xfer = rst_n && out_valid && out_ready;
    if (out_xfer) begin
      if (pending_levels.size() == 0) begin
        report_mismatch($sformatf("result with no tick pending (level %0d, active %b)",
                                  out_data.pwm_level, out_data.active_voices));
      end else begin
        mix_want = pending_levels.pop_front();
        results_checked++;
        if (out_data.pwm_level !== mix_want.pwm_level)
          report_mismatch($sformatf("pwm_level got %0d expected %0d",
                                    out_data.pwm_level, mix_want.pwm_level));
        if (out_data.active_voices !== mix_want.active_voices)
          report_mismatch($sformatf("active_voices got %b expected %b",
                                    out_data.active_voices, mix_want.active_voices));
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_xfer) out_stall = $urandom_range(0, out_stall_max);
      out_ready <= (out_stall == 0);
      // count the stall down only while a result is waiting
      if (out_stall > 0 && out_valid) out_stall--;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d levels outstanding",
               cycle_count, pending_levels.size());
      $display("multi_voice_sample_mixer_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int v;
    int p;
    int r;
    int made;
    int idx;
    logic [DATA_W-1:0] per;

    for (v = 0; v < VOICES; v++) begin
      len_cfg[v] = '0;
      play_pos[v] = '0;
      playing[v] = 1'b0;
      filled_to[v] = 0;
      armed[v] = 1'b0;
    end
    period_cfg = mvsm_pkg::PERIOD_RESET;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: short lengths, a period of 2^16. Voice 3's length is written with
    // the spare high bits set, which must be masked off. Voice 2 gets length
    // zero, so once triggered it stays active and never plays.
    write_reg(mvsm_pkg::CFG_VOICE0_LENGTH, 17'd3);
    write_reg(mvsm_pkg::CFG_VOICE1_LENGTH, 17'd2);
    write_reg(mvsm_pkg::CFG_VOICE2_LENGTH, 17'd0);
    write_reg(mvsm_pkg::CFG_VOICE3_LENGTH, 17'h18001);
    write_reg(mvsm_pkg::CFG_PWM_PERIOD, 17'h10000);

    queue_command(mvsm_pkg::CMD_TICK, 0, 0, 0);                 // silence: mid-scale level
    queue_command(mvsm_pkg::CMD_WRITE, 0, 0, mvsm_pkg::MIX_MAX);
    queue_command(mvsm_pkg::CMD_WRITE, 0, 1, mvsm_pkg::MIX_MIN);
    queue_command(mvsm_pkg::CMD_WRITE, 0, 2, 'h5555);
    queue_command(mvsm_pkg::CMD_WRITE, 1, 0, mvsm_pkg::MIX_MIN);
    queue_command(mvsm_pkg::CMD_WRITE, 1, 1, mvsm_pkg::MIX_MAX);
    queue_command(mvsm_pkg::CMD_WRITE, 3, 0, -1);
    queue_command(mvsm_pkg::CMD_WRITE, 2, DEPTH - 1, pick_sample());  // top frame address
    for (v = 0; v < VOICES; v++) queue_command(mvsm_pkg::CMD_TRIGGER, v, 0, 0);
    // three voices sum to -2: divide by 3 truncates to 0, not -1
    queue_command(mvsm_pkg::CMD_TICK, 0, 0, 0);
    // two voices sum to -1: halves to 0; voice 1 ends here
    queue_command(mvsm_pkg::CMD_TICK, 0, 0, 0);
    queue_command(mvsm_pkg::CMD_TICK, 0, 0, 0);
    queue_command(mvsm_pkg::CMD_TICK, 0, 0, 0);        // only the zero-length voice left
    queue_command(CMD_UNUSED, 3, DEPTH - 1, -1);       // unused command: no result
    queue_command(mvsm_pkg::CMD_TRIGGER, 0, 0, 0);
    queue_command(mvsm_pkg::CMD_TICK, 0, 0, 0);        // top rail: level hits period-1
    queue_command(mvsm_pkg::CMD_TICK, 0, 0, 0);        // bottom rail: level 0
    queue_command(mvsm_pkg::CMD_TICK, 0, 0, 0);
    wait_idle();

    // Random phases. Each one retunes every register between drains, walking
    // the period through its extremes (zero, one, above 16 bits).
    for (p = 0; p < NUM_PHASES; p++) begin
      in_gap_max = (p % 3 == 1) ? 0 : 9;
      out_stall_max = (p % 4 == 2) ? 0 : 9;
      case (p)
        0: per = 17'd1;
        1: per = 17'd0;
        2: per = 17'h1FFFF;
        3: per = mvsm_pkg::PERIOD_RESET;
        4: per = 17'h10000;
        6: per = 17'd2;
        default: per = DATA_W'($urandom_range(1, 17'h1FFFF));
      endcase
      for (v = 0; v < VOICES; v++)
        write_reg(mvsm_pkg::CFG_VOICE0_LENGTH + IDX_W'(v),
                  {2'($urandom_range(0, 3)), pick_length(v)});
      write_reg(mvsm_pkg::CFG_PWM_PERIOD, per);
      if (p == 0)
        for (idx = CFG_UNMAPPED_LO; idx <= CFG_UNMAPPED_HI; idx++)
          write_reg(IDX_W'(idx), DATA_W'($urandom));

      made = 0;
      while (made < PER_PHASE) begin
        v = $urandom_range(0, VOICES - 1);
        r = $urandom_range(0, 99);
        if (r < 45) begin
          queue_command(mvsm_pkg::CMD_TICK, v, $urandom_range(0, DEPTH - 1), pick_sample());
          made++;
        end else if (r < 60 && can_trigger(v)) begin
          queue_command(mvsm_pkg::CMD_TRIGGER, v, $urandom_range(0, DEPTH - 1),
                        pick_sample());
          made++;
        end else if (r < 92) begin
          // mostly grow the voice's written prefix, sometimes scatter
          if (r < 84 && filled_to[v] < DEPTH)
            queue_command(mvsm_pkg::CMD_WRITE, v, filled_to[v], pick_sample());
          else
            queue_command(mvsm_pkg::CMD_WRITE, v, $urandom_range(0, DEPTH - 1),
                          pick_sample());
          made++;
        end else begin
          queue_command(CMD_UNUSED, v, $urandom_range(0, DEPTH - 1), pick_sample());
        end
      end
      wait_idle();
    end

    if (pending_levels.size() != 0)
      report_mismatch($sformatf("%0d expected levels never arrived", pending_levels.size()));

    $display("run covered %0d ticks (%0d levels checked), %0d sample writes, %0d triggers",
             ticks_done, results_checked, writes_done, triggers_done);
    $display("plus %0d unused commands and %0d register writes; %0d mismatches",
             ignored_done, reg_writes, errors);
    if (errors == 0) begin
      $display("multi_voice_sample_mixer_tb: PASS");
    end else begin
      $display("multi_voice_sample_mixer_tb: FAIL");
    end
    $finish;
  end

endmodule
